// ----- rtl/qrs_pkg.sv -----
// shared constants for the quadratic root solver
`default_nettype none

package qrs_pkg;

  localparam int OUT_WIDTH = 34;

  localparam logic [1:0] CASE_INF  = 2'd0;
  localparam logic [1:0] CASE_NONE = 2'd1;
  localparam logic [1:0] CASE_ONE  = 2'd2;
  localparam logic [1:0] CASE_TWO  = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/quadratic_root_solver.sv -----
// top level of the quadratic root solver pipeline
`default_nettype none

// Real roots of a*x^2+b*x+c=0, one coefficient triple per clock. busy is high during
// reset and in the cycle after it; otherwise every start beat is taken. Each item
// passes from its start beat to its done strobe through the capture, product and
// discriminant registers, the square root chain (one cell per root bit), the prep
// register, the divide chain (one cell per quotient bit) and the output register. The
// receiver cannot stall, so results must be taken in the cycle they appear.
module quadratic_root_solver #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [COEF_WIDTH-1:0]          coef_quad,
  input  wire logic signed [COEF_WIDTH-1:0]          coef_lin,
  input  wire logic signed [COEF_WIDTH-1:0]          coef_const,
  output logic                                       done,
  output logic [1:0]                                 root_case,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0]       root_first,
  output logic signed [qrs_pkg::OUT_WIDTH-1:0]       root_second
);

  localparam int CW   = COEF_WIDTH;
  localparam int OW   = qrs_pkg::OUT_WIDTH;
  localparam int PW   = 2 * CW;
  localparam int DW   = 2 * CW + 1;
  localparam int SW   = CW + FRAC_BITS + 1;
  localparam int RW   = 2 * SW;
  localparam int NBW  = CW + FRAC_BITS + 1;
  localparam int NW   = CW + FRAC_BITS + 2;
  localparam int DVW  = CW + 1;
  localparam int SQ_SIDE = 3 + NBW + DVW;
  localparam int DV_SIDE = 4;
  localparam int EW   = ((NW > OW) ? NW : OW) + 1;
  localparam int LAT  = 5 + SW + NW;

  logic accept;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // stage 1: capture
  logic                 v1;
  logic signed [CW-1:0] a1, b1, c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    a1 <= coef_quad;
    b1 <= coef_lin;
    c1 <= coef_const;
  end

  // stage 2: magnitudes and products
  logic [CW-1:0]        amag, bmag, cmag;
  logic                 v2, acneg2;
  logic [PW-1:0]        bsq2, p2;
  logic signed [CW-1:0] a2, b2, c2;

  always_comb begin
    amag = a1[CW-1] ? CW'(-a1) : CW'(a1);
    bmag = b1[CW-1] ? CW'(-b1) : CW'(b1);
    cmag = c1[CW-1] ? CW'(-c1) : CW'(c1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    bsq2   <= PW'(bmag) * PW'(bmag);
    p2     <= PW'(amag) * PW'(cmag);
    acneg2 <= (a1[CW-1] != c1[CW-1]) && (a1 != '0) && (c1 != '0);
    a2     <= a1;
    b2     <= b1;
    c2     <= c1;
  end

  // stage 3: discriminant, case and divider operands
  logic [DW:0]           four_ac, bsq_x, dsum, ddiff;
  logic [DW-1:0]         disc;
  logic [1:0]            case_n;
  logic signed [NBW-1:0] nb_n;
  logic signed [DVW-1:0] den_n;
  logic signed [NBW-1:0] bx, cx;

  always_comb begin
    four_ac = {p2, 2'b00};
    bsq_x   = {2'b00, bsq2};
    dsum    = bsq_x + four_ac;
    ddiff   = bsq_x - four_ac;
    bx      = NBW'(b2);
    cx      = NBW'(c2);
    disc    = '0;
    nb_n    = (-bx) <<< FRAC_BITS;
    den_n   = DVW'(a2) <<< 1;
    if (a2 == '0) begin
      den_n = DVW'(b2);
      nb_n  = (-cx) <<< FRAC_BITS;
      if (b2 == '0) begin
        case_n = (c2 == '0) ? qrs_pkg::CASE_INF : qrs_pkg::CASE_NONE;
      end else begin
        case_n = qrs_pkg::CASE_ONE;
      end
    end else if (acneg2) begin
      case_n = qrs_pkg::CASE_TWO;
      disc   = dsum[DW-1:0];
    end else if (four_ac > bsq_x) begin
      case_n = qrs_pkg::CASE_NONE;
    end else if (four_ac == bsq_x) begin
      case_n = qrs_pkg::CASE_ONE;
    end else begin
      case_n = qrs_pkg::CASE_TWO;
      disc   = ddiff[DW-1:0];
    end
  end

  logic               v3;
  logic [RW-1:0]      rad3;
  logic [SQ_SIDE-1:0] side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    // radicand is the discriminant scaled by 2^(2*FRAC_BITS)
    rad3  <= {1'b0, disc, {(2 * FRAC_BITS){1'b0}}};
    side3 <= {case_n, (case_n == qrs_pkg::CASE_TWO), nb_n, den_n};
  end

  // square root chain
  logic               sq_v    [0:SW];
  logic [RW-1:0]      sq_rad  [0:SW];
  logic [SW:0]        sq_rem  [0:SW];
  logic [SW-1:0]      sq_root [0:SW];
  logic [SQ_SIDE-1:0] sq_side [0:SW];

  assign sq_v[0]    = v3;
  assign sq_rad[0]  = rad3;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = side3;

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell #(.SW(SW), .SIDE_W(SQ_SIDE)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sq_v[i]),
      .in_rad   (sq_rad[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_side  (sq_side[i]),
      .out_valid(sq_v[i+1]),
      .out_rad  (sq_rad[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  // prep: numerators, magnitudes and quotient signs
  logic [1:0]            case_s;
  logic                  two_s;
  logic signed [NBW-1:0] nb_s;
  logic signed [DVW-1:0] den_s;
  logic signed [NW:0]    nbx, sx, n1, n2;
  logic [NW-1:0]         m1, m2;
  logic [DVW-1:0]        dmag;

  always_comb begin
    {case_s, two_s, nb_s, den_s} = sq_side[SW];
    nbx = (NW+1)'(nb_s);
    sx  = (NW+1)'(sq_root[SW]);
    n1  = '0;
    n2  = '0;
    if (two_s) begin
      n1 = nbx - sx;
      n2 = nbx + sx;
    end else if (case_s == qrs_pkg::CASE_ONE) begin
      n1 = nbx;
    end
    m1   = n1[NW] ? NW'(-n1) : NW'(n1);
    m2   = n2[NW] ? NW'(-n2) : NW'(n2);
    dmag = den_s[DVW-1] ? DVW'(-den_s) : DVW'(den_s);
    if (dmag == '0) begin
      dmag = DVW'(1);
    end
  end

  logic               vp;
  logic [DVW-1:0]     denp;
  logic [NW-1:0]      num1p, num2p;
  logic [DV_SIDE-1:0] sidep;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else begin
      vp <= sq_v[SW];
    end
    denp  <= dmag;
    num1p <= m1;
    num2p <= m2;
    sidep <= {case_s, n1[NW] ^ den_s[DVW-1], n2[NW] ^ den_s[DVW-1]};
  end

  // divide chain
  logic               dv_v    [0:NW];
  logic [DVW-1:0]     dv_den  [0:NW];
  logic [NW-1:0]      dv_num1 [0:NW];
  logic [DVW-1:0]     dv_rem1 [0:NW];
  logic [NW-1:0]      dv_num2 [0:NW];
  logic [DVW-1:0]     dv_rem2 [0:NW];
  logic [DV_SIDE-1:0] dv_side [0:NW];

  assign dv_v[0]    = vp;
  assign dv_den[0]  = denp;
  assign dv_num1[0] = num1p;
  assign dv_rem1[0] = '0;
  assign dv_num2[0] = num2p;
  assign dv_rem2[0] = '0;
  assign dv_side[0] = sidep;

  for (genvar j = 0; j < NW; j++) begin : g_div
    qrs_div_cell #(.NW(NW), .DVW(DVW), .SIDE_W(DV_SIDE)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dv_v[j]),
      .in_den   (dv_den[j]),
      .in_num1  (dv_num1[j]),
      .in_rem1  (dv_rem1[j]),
      .in_num2  (dv_num2[j]),
      .in_rem2  (dv_rem2[j]),
      .in_side  (dv_side[j]),
      .out_valid(dv_v[j+1]),
      .out_den  (dv_den[j+1]),
      .out_num1 (dv_num1[j+1]),
      .out_rem1 (dv_rem1[j+1]),
      .out_num2 (dv_num2[j+1]),
      .out_rem2 (dv_rem2[j+1]),
      .out_side (dv_side[j+1])
    );
  end

  // sign and saturate to the output range
  function automatic logic [OW-1:0] fix_out(input logic [NW-1:0] q, input logic neg);
    logic [EW-1:0] qe;
    logic [EW-1:0] lim;
    logic [EW-1:0] val;
    qe  = EW'(q);
    lim = EW'(1) << (OW - 1);
    val = neg ? (~qe + EW'(1)) : qe;
    if (!neg && qe >= lim) begin
      fix_out = {1'b0, {(OW - 1){1'b1}}};
    end else if (neg && qe > lim) begin
      fix_out = {1'b1, {(OW - 1){1'b0}}};
    end else begin
      fix_out = val[OW-1:0];
    end
  endfunction

  logic [1:0] case_d;
  logic       neg1_d, neg2_d;

  assign {case_d, neg1_d, neg2_d} = dv_side[NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_v[NW];
    end
    root_case   <= case_d;
    root_first  <= fix_out(dv_num1[NW], neg1_d);
    root_second <= fix_out(dv_num2[NW], neg2_d);
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result beat missing after pipeline latency");

  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    (done && root_case != qrs_pkg::CASE_TWO) |-> (root_second == '0))
    else $error("second root set without two roots");

  a_first_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (root_case == qrs_pkg::CASE_INF || root_case == qrs_pkg::CASE_NONE))
      |-> (root_first == '0))
    else $error("first root set without a root");

  a_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown({root_case, root_first, root_second}))
    else $error("unknown bits on a result beat");

endmodule

`default_nettype wire

// ----- rtl/qrs_sqrt_cell.sv -----
// one digit-by-digit square root cell: resolves one root bit per clock
`default_nettype none

module qrs_sqrt_cell #(
  parameter int SW     = 49,
  parameter int SIDE_W = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [2*SW-1:0]     in_rad,
  input  wire logic [SW:0]         in_rem,
  input  wire logic [SW-1:0]       in_root,
  input  wire logic [SIDE_W-1:0]   in_side,
  output logic                     out_valid,
  output logic [2*SW-1:0]          out_rad,
  output logic [SW:0]              out_rem,
  output logic [SW-1:0]            out_root,
  output logic [SIDE_W-1:0]        out_side
);

  logic [SW+2:0] rem_sh;
  logic [SW+2:0] trial;
  logic [SW+2:0] diff;
  logic [SW:0]   rem_next;
  logic [SW-1:0] root_next;

  always_comb begin
    rem_sh = {in_rem, in_rad[2*SW-1:2*SW-2]};
    trial  = {1'b0, in_root, 2'b01};
    diff   = rem_sh - trial;
    if (rem_sh >= trial) begin
      rem_next  = diff[SW:0];
      root_next = {in_root[SW-2:0], 1'b1};
    end else begin
      rem_next  = rem_sh[SW:0];
      root_next = {in_root[SW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rad  <= {in_rad[2*SW-3:0], 2'b00};
    out_rem  <= rem_next;
    out_root <= root_next;
    out_side <= in_side;
  end

endmodule

`default_nettype wire

// ----- rtl/qrs_div_cell.sv -----
// one restoring divide cell: one quotient bit per clock for two dividends over one divisor
`default_nettype none

module qrs_div_cell #(
  parameter int NW     = 34,
  parameter int DVW    = 17,
  parameter int SIDE_W = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [DVW-1:0]    in_den,
  input  wire logic [NW-1:0]     in_num1,
  input  wire logic [DVW-1:0]    in_rem1,
  input  wire logic [NW-1:0]     in_num2,
  input  wire logic [DVW-1:0]    in_rem2,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [DVW-1:0]         out_den,
  output logic [NW-1:0]          out_num1,
  output logic [DVW-1:0]         out_rem1,
  output logic [NW-1:0]          out_num2,
  output logic [DVW-1:0]         out_rem2,
  output logic [SIDE_W-1:0]      out_side
);

  logic [DVW:0]   sh1, sh2, d1, d2, den_x;
  logic           ge1, ge2;

  always_comb begin
    den_x = {1'b0, in_den};
    sh1   = {in_rem1, in_num1[NW-1]};
    sh2   = {in_rem2, in_num2[NW-1]};
    ge1   = sh1 >= den_x;
    ge2   = sh2 >= den_x;
    d1    = sh1 - den_x;
    d2    = sh2 - den_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_den  <= in_den;
    out_num1 <= {in_num1[NW-2:0], ge1};
    out_num2 <= {in_num2[NW-2:0], ge2};
    out_rem1 <= ge1 ? d1[DVW-1:0] : sh1[DVW-1:0];
    out_rem2 <= ge2 ? d2[DVW-1:0] : sh2[DVW-1:0];
    out_side <= in_side;
  end

endmodule

`default_nettype wire
